// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/dtq_pkg.sv -----
`default_nettype none

package dtq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 16;
  localparam int DEF_ID_BITS     = 8;

  localparam int KIND_W    = 2;
  localparam int IN_ID_W   = 8;
  localparam int IN_TIME_W = 16;
  localparam int STATUS_W  = 2;
  localparam int OUT_ID_W  = 8;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [IN_ID_W-1:0]   thread_id;
    logic [IN_TIME_W-1:0] wait_time;
    logic [IN_ID_W-1:0]   sem_id;
  } dtq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_ID_W-1:0] popped_thread;
    logic [OUT_ID_W-1:0] popped_sem;
    logic                now_empty;
  } dtq_out_t;

endpackage

`default_nettype wire

// ----- rtl/dtq_in_if.sv -----
`default_nettype none

interface dtq_in_if;
  import dtq_pkg::*;

  logic    valid;
  logic    ready;
  dtq_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dtq_out_if.sv -----
`default_nettype none

interface dtq_out_if;
  import dtq_pkg::*;

  logic     valid;
  logic     ready;
  dtq_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dtq_node_ram.sv -----
`default_nettype none

module dtq_node_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dtq_ctrl.sv -----
`default_nettype none

module dtq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 16,
  parameter int ID_BITS     = 8,
  parameter int PW          = $clog2(QUEUE_DEPTH),
  parameter int NW          = PW + TIME_BITS + 2 * ID_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  dtq_in_if.sink             in_ch,
  dtq_out_if.source          out_ch,
  output logic               mem_we,
  output logic [PW-1:0]      mem_waddr,
  output logic [NW-1:0]      mem_wdata,
  output logic               mem_re,
  output logic [PW-1:0]      mem_raddr,
  input  wire logic [NW-1:0] mem_rdata
);
  import dtq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PW-1:0]        nxt;
    logic [TIME_BITS-1:0] delta;
    logic [ID_BITS-1:0]   sem;
    logic [ID_BITS-1:0]   thr;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_IWALK, S_ISUCC, S_INEW, S_ILINK,
    S_RWALK, S_RSUCC, S_RLINK, S_RFREE, S_POP, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] fl_head_r, fl_head_nxt;    // head of the freed-slot list
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] hw_r, hw_nxt;              // slots ever taken from the fresh pool
  logic [CW-1:0] i_r, i_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] prev_ptr_r, prev_ptr_nxt;
  logic          prev_v_r, prev_v_nxt;
  node_t         prev_r, prev_nxt;
  node_t         node_r, node_nxt;
  logic [PW-1:0] slot_r, slot_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [ID_BITS-1:0]   tid_r, tid_nxt;
  logic [ID_BITS-1:0]   sid_r, sid_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [OUT_ID_W-1:0]  pt_r, pt_nxt;
  logic [OUT_ID_W-1:0]  ps_r, ps_nxt;
  logic          out_valid_r, out_valid_nxt;
  dtq_out_t      out_data_r, out_data_nxt;

  node_t rd;
  node_t wr;
  logic [TIME_BITS:0] sum;

  assign rd          = node_t'(mem_rdata);
  assign mem_wdata   = NW'(wr);
  assign sum         = {1'b0, rd.delta} + {1'b0, node_r.delta};
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fl_head_nxt   = fl_head_r;
    count_nxt     = count_r;
    hw_nxt        = hw_r;
    i_nxt         = i_r;
    cur_nxt       = cur_r;
    prev_ptr_nxt  = prev_ptr_r;
    prev_v_nxt    = prev_v_r;
    prev_nxt      = prev_r;
    node_nxt      = node_r;
    slot_nxt      = slot_r;
    rem_nxt       = rem_r;
    tid_nxt       = tid_r;
    sid_nxt       = sid_r;
    status_nxt    = status_r;
    pt_nxt        = pt_r;
    ps_nxt        = ps_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r;
    wr            = node_r;
    mem_re        = 1'b0;
    mem_raddr     = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          tid_nxt    = ID_BITS'(in_ch.data.thread_id);
          sid_nxt    = ID_BITS'(in_ch.data.sem_id);
          rem_nxt    = TIME_BITS'(in_ch.data.wait_time);
          i_nxt      = '0;
          prev_v_nxt = 1'b0;
          cur_nxt    = head_r;
          pt_nxt     = '0;
          ps_nxt     = '0;
          status_nxt = ST_OK;
          case (in_ch.data.kind)
            KIND_INSERT: begin
              if (count_r == CW'(QUEUE_DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (hw_r != count_r) begin
                mem_re    = 1'b1;
                mem_raddr = fl_head_r;
                state_nxt = S_ALLOC;
              end else begin
                slot_nxt  = hw_r[PW-1:0];
                hw_nxt    = hw_r + CW'(1);
                mem_re    = 1'b1;
                state_nxt = S_IWALK;
              end
            end
            KIND_REMOVE: begin
              mem_re    = 1'b1;
              state_nxt = S_RWALK;
            end
            KIND_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_POP;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_ALLOC: begin
        slot_nxt    = fl_head_r;
        fl_head_nxt = rd.nxt;
        mem_re      = 1'b1;
        state_nxt   = S_IWALK;
      end

      // one entry per cycle; next read address comes straight from the read data
      S_IWALK: begin
        if ((i_r < count_r) && (rd.delta < rem_r)) begin
          rem_nxt      = rem_r - rd.delta;
          prev_nxt     = rd;
          prev_ptr_nxt = cur_r;
          prev_v_nxt   = 1'b1;
          cur_nxt      = rd.nxt;
          i_nxt        = i_r + CW'(1);
          mem_re       = 1'b1;
          mem_raddr    = rd.nxt;
        end else begin
          node_nxt  = rd;
          state_nxt = S_ISUCC;
        end
      end

      S_ISUCC: begin
        if (i_r < count_r) begin
          mem_we    = 1'b1;
          mem_waddr = cur_r;
          wr.delta  = node_r.delta - rem_r;
        end
        state_nxt = S_INEW;
      end

      S_INEW: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r;
        wr.nxt    = cur_r;
        wr.delta  = rem_r;
        wr.sem    = sid_r;
        wr.thr    = tid_r;
        state_nxt = S_ILINK;
      end

      S_ILINK: begin
        if (prev_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = prev_ptr_r;
          wr        = prev_r;
          wr.nxt    = slot_r;
        end else begin
          head_nxt = slot_r;
        end
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_RWALK: begin
        if (i_r == count_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else if (rd.thr == tid_r) begin
          node_nxt = rd;
          if ((i_r + CW'(1)) < count_r) begin
            mem_re    = 1'b1;
            mem_raddr = rd.nxt;
            state_nxt = S_RSUCC;
          end else begin
            state_nxt = S_RLINK;
          end
        end else begin
          prev_nxt     = rd;
          prev_ptr_nxt = cur_r;
          prev_v_nxt   = 1'b1;
          cur_nxt      = rd.nxt;
          i_nxt        = i_r + CW'(1);
          mem_re       = 1'b1;
          mem_raddr    = rd.nxt;
        end
      end

      // successor absorbs the removed delta, saturating
      S_RSUCC: begin
        mem_we    = 1'b1;
        mem_waddr = node_r.nxt;
        wr        = rd;
        wr.delta  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        state_nxt = S_RLINK;
      end

      S_RLINK: begin
        if (prev_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = prev_ptr_r;
          wr        = prev_r;
          wr.nxt    = node_r.nxt;
        end else begin
          head_nxt = node_r.nxt;
        end
        state_nxt = S_RFREE;
      end

      S_RFREE: begin
        mem_we      = 1'b1;
        mem_waddr   = cur_r;
        wr.nxt      = fl_head_r;
        fl_head_nxt = cur_r;
        count_nxt   = count_r - CW'(1);
        state_nxt   = S_DONE;
      end

      S_POP: begin
        pt_nxt    = OUT_ID_W'(rd.thr);
        ps_nxt    = OUT_ID_W'(rd.sem);
        node_nxt  = rd;
        head_nxt  = rd.nxt;
        state_nxt = S_RFREE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.popped_thread = pt_r;
          out_data_nxt.popped_sem    = ps_r;
          out_data_nxt.now_empty     = (count_r == '0);
          state_nxt                  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fl_head_r   <= '0;
      count_r     <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fl_head_r   <= fl_head_nxt;
      count_r     <= count_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    cur_r      <= cur_nxt;
    prev_ptr_r <= prev_ptr_nxt;
    prev_v_r   <= prev_v_nxt;
    prev_r     <= prev_nxt;
    node_r     <= node_nxt;
    slot_r     <= slot_nxt;
    rem_r      <= rem_nxt;
    tid_r      <= tid_nxt;
    sid_r      <= sid_nxt;
    status_r   <= status_nxt;
    pt_r       <= pt_nxt;
    ps_r       <= ps_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/delta_timer_queue.sv -----
// Sleep queue kept as a delta list, one request word in, one result word out.
// in_ch carries kind (insert, remove by thread id, pop head), thread_id,
// wait_time and sem_id; out_ch carries status, popped_thread, popped_sem and
// now_empty. Both use valid/ready; a word moves when both are high.
// Entries live in one node RAM (one write, one registered read per cycle) as
// a linked list with a free list; the RAM is never cleared.
// An insert walks the list (after a free-list read when it reuses a freed slot),
// then writes the successor, the new node and the link; a remove walks, then
// fixes the successor and link and frees the slot; pop frees the head slot.
// The list walk reads one node per cycle through the RAM read port; each
// write-back takes the single write port.
// One request is in flight at a time; in_ch.ready is high only when idle.
// A finished result sits in the output register while the next request is
// taken; if out_ch.ready stays low, the following result waits in the control
// block and the input stays closed.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module delta_timer_queue #(
  parameter int QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = dtq_pkg::DEF_TIME_BITS,
  parameter int ID_BITS     = dtq_pkg::DEF_ID_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dtq_in_if.sink    in_ch,
  dtq_out_if.source out_ch
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = PW + TIME_BITS + 2 * ID_BITS;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [NW-1:0] mem_wdata;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  logic [NW-1:0] mem_rdata;

  dtq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS),
    .ID_BITS    (ID_BITS),
    .PW         (PW),
    .NW         (NW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  dtq_node_ram #(
    .WIDTH(NW),
    .DEPTH(QUEUE_DEPTH),
    .AW   (PW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/dtq_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module dtq_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire dtq_pkg::dtq_out_t out_data
);
  import dtq_pkg::*;

  logic [2:0] occ_r, occ_nxt;   // requests taken minus results delivered

  assign occ_nxt = occ_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMP(a_no_extra_result, clk, rst_n, out_valid, occ_r != 3'd0)
  `ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_r <= 3'd2)
  `ASSERT_IMP(a_full_not_empty, clk, rst_n, out_valid && (out_data.status == ST_FULL), !out_data.now_empty)
  `ASSERT_IMP(a_fail_no_pop, clk, rst_n, out_valid && (out_data.status != ST_OK), (out_data.popped_thread == '0) && (out_data.popped_sem == '0))

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data)
);

`default_nettype wire
